// ----- design/kms_pkg.sv -----
`default_nettype none
package kms_pkg;

  localparam int KEY_ROWS_MAX = 4;
  localparam int KEY_COLS_MAX = 4;
  localparam int ROWS_DEFAULT = 4;
  localparam int COLS_DEFAULT = 4;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_TICKS  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODES_LOW    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODES_HIGH   = 8'd3;

  localparam logic [15:0] SETTLE_RESET     = 16'd1;
  localparam logic [15:0] PAUSE_RESET      = 16'd10;
  localparam logic [63:0] CODES_LOW_RESET  = 64'h2322_2112_202E_301E;
  localparam logic [63:0] CODES_HIGH_RESET = 64'h1831_321C_2625_2417;

  typedef struct packed {
    logic [3:0]      drive;
    logic [1:0]      row;
    logic [3:0]      report;
    logic [3:0]      down;
    logic [3:0][7:0] code;
  } tick_set_t;

  function automatic logic [7:0] key_code_of(input logic [63:0] low_half,
                                             input logic [63:0] high_half,
                                             input logic [1:0]  row,
                                             input logic [1:0]  col);
    logic [63:0] half;
    logic [2:0]  pos;
    half = row[1] ? high_half : low_half;
    pos  = {row[0], col};
    return half[pos*8 +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- design/kms_lane.sv -----
`default_nettype none
module kms_lane (
  input  wire logic       level,
  input  wire logic       was_pressed,
  input  wire logic [7:0] code,
  output logic            toggle,
  output logic            down,
  output logic            report
);

  assign down   = ~level;
  assign toggle = down != was_pressed;
  assign report = toggle && (code != 8'd0);

endmodule
`default_nettype wire

// ----- design/kms_merge.sv -----
`default_nettype none
module kms_merge (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire kms_pkg::tick_set_t push_set,
  output logic                   push_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             row_drive,
  output logic                   event_valid,
  output logic                   key_down,
  output logic [7:0]             key_code,
  output logic [1:0]             key_row,
  output logic [1:0]             key_column,
  output logic                   last_of_tick
);
  import kms_pkg::*;

  logic      a_valid;
  tick_set_t a_set;
  logic      b_valid;
  tick_set_t b_set;
  logic [3:0] b_mask;

  logic [3:0] sel;
  logic [1:0] col;
  logic       evt;
  logic       last;
  logic       b_take;
  logic       b_free;
  logic       a_move;

  always_comb begin
    sel = b_mask & (~b_mask + 4'd1);
    col = 2'd0;
    for (int i = 0; i < KEY_COLS_MAX; i++) begin
      if (sel[i]) begin
        col = 2'(i);
      end
    end
  end

  assign evt    = b_mask != 4'd0;
  assign last   = (b_mask & (b_mask - 4'd1)) == 4'd0;
  assign b_take = b_valid && !out_stall;
  assign b_free = !b_valid || (b_take && last);
  assign a_move = a_valid && b_free;
  assign push_ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (push) begin
        a_valid <= 1'b1;
        a_set   <= push_set;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        b_valid <= 1'b1;
        b_set   <= a_set;
        b_mask  <= a_set.report;
      end else if (b_take) begin
        if (last) begin
          b_valid <= 1'b0;
        end else begin
          b_mask <= b_mask & ~sel;
        end
      end
    end
  end

  assign out_valid    = b_valid;
  assign row_drive    = b_set.drive;
  assign event_valid  = evt;
  assign key_down     = evt ? b_set.down[col] : 1'b0;
  assign key_code     = evt ? b_set.code[col] : 8'd0;
  assign key_row      = evt ? b_set.row : 2'd0;
  assign key_column   = evt ? col : 2'd0;
  assign last_of_tick = last;

endmodule
`default_nettype wire

// ----- design/key_matrix_scanner.sv -----
// Key matrix scanner. Each input beat is one time tick carrying the raw column
// levels; the block drives one row low per scan step, holds it for settle_ticks
// ticks, then samples all columns at once in parallel lanes, updates the pressed
// map and emits one output beat per reported key change (press or release, in
// column order), or a single beat with event_valid low when nothing is
// reported. Every beat carries the row drive for its tick and last_of_tick
// marks the final beat of a tick. After the last row all rows go high for
// scan_pause_ticks ticks. The state update for a tick is done at its acceptance;
// the merge stage that serializes beats gives one output beat per reported
// change (at least one beat per tick), so the sustained rate is one tick per
// cycle when ticks give a single beat and the output does not stall, and lower
// otherwise. Two tick sets are buffered, so a new tick is taken while earlier
// beats wait. Configuration writes are always ready; indexes beyond 3 are
// ignored.
`default_nettype none
module key_matrix_scanner #(
  parameter int ROWS = kms_pkg::ROWS_DEFAULT,
  parameter int COLS = kms_pkg::COLS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [3:0]                      column_levels,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [3:0]                           row_drive,
  output logic                                 event_valid,
  output logic                                 key_down,
  output logic [7:0]                           key_code,
  output logic [1:0]                           key_row,
  output logic [1:0]                           key_column,
  output logic                                 last_of_tick
);
  import kms_pkg::*;

  typedef enum logic [1:0] {
    PH_SETTLE,
    PH_PAUSE
  } phase_t;

  localparam logic [2:0] ROWS_W   = 3'(ROWS);
  localparam logic [1:0] LAST_ROW = 2'(ROWS - 1);

  logic [15:0] settle_ticks;
  logic [15:0] scan_pause_ticks;
  logic [63:0] keycodes_low_half;
  logic [63:0] keycodes_high_half;

  phase_t      scan_phase;
  phase_t      scan_phase_next;
  logic [1:0]  current_row;
  logic [1:0]  current_row_next;
  logic [15:0] phase_count;
  logic [15:0] phase_count_next;
  logic [15:0] pressed_map;
  logic [15:0] pressed_map_next;

  logic        accept;
  logic        push_ready;
  logic [1:0]  row_eff;
  logic [15:0] count_inc;
  logic        sample;
  logic [3:0]  toggle;
  logic [3:0]  down;
  logic [3:0]  report;
  logic [3:0][7:0] code;
  tick_set_t   set;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && push_ready;
  assign in_stall  = !push_ready;

  assign row_eff   = ({1'b0, current_row} >= ROWS_W) ? 2'd0 : current_row;
  assign count_inc = phase_count + 16'd1;
  assign sample    = (scan_phase != PH_PAUSE) && (phase_count >= settle_ticks);

  for (genvar c = 0; c < KEY_COLS_MAX; c++) begin : g_lane
    assign code[c] = key_code_of(keycodes_low_half, keycodes_high_half, row_eff, 2'(c));
    if (c < COLS) begin : g_used
      kms_lane u_lane (
        .level       (column_levels[c]),
        .was_pressed (pressed_map[{row_eff, 2'(c)}]),
        .code        (code[c]),
        .toggle      (toggle[c]),
        .down        (down[c]),
        .report      (report[c])
      );
    end else begin : g_unused
      assign toggle[c] = 1'b0;
      assign down[c]   = 1'b0;
      assign report[c] = 1'b0;
    end
  end

  always_comb begin
    scan_phase_next  = scan_phase;
    current_row_next = current_row;
    phase_count_next = phase_count;
    pressed_map_next = pressed_map;
    set.drive  = 4'hF;
    set.row    = row_eff;
    set.report = 4'd0;
    set.down   = down;
    set.code   = code;
    if (scan_phase == PH_PAUSE) begin
      phase_count_next = count_inc;
      if (count_inc >= scan_pause_ticks) begin
        phase_count_next = 16'd0;
        current_row_next = 2'd0;
        scan_phase_next  = PH_SETTLE;
      end
    end else begin
      set.drive = ~(4'b0001 << row_eff);
      if (!sample) begin
        phase_count_next = count_inc;
        current_row_next = row_eff;
        scan_phase_next  = PH_SETTLE;
      end else begin
        set.report = report;
        for (int c = 0; c < KEY_COLS_MAX; c++) begin
          if (toggle[c]) begin
            pressed_map_next[{row_eff, 2'(c)}] = ~pressed_map[{row_eff, 2'(c)}];
          end
        end
        phase_count_next = 16'd0;
        if (row_eff == LAST_ROW) begin
          current_row_next = 2'd0;
          scan_phase_next  = (scan_pause_ticks != 16'd0) ? PH_PAUSE : PH_SETTLE;
        end else begin
          current_row_next = row_eff + 2'd1;
          scan_phase_next  = PH_SETTLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks       <= SETTLE_RESET;
      scan_pause_ticks   <= PAUSE_RESET;
      keycodes_low_half  <= CODES_LOW_RESET;
      keycodes_high_half <= CODES_HIGH_RESET;
      scan_phase         <= PH_SETTLE;
      current_row        <= 2'd0;
      phase_count        <= 16'd0;
      pressed_map        <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETTLE_TICKS: settle_ticks       <= cfg_data[15:0];
          REG_PAUSE_TICKS:  scan_pause_ticks   <= cfg_data[15:0];
          REG_CODES_LOW:    keycodes_low_half  <= cfg_data;
          REG_CODES_HIGH:   keycodes_high_half <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        scan_phase  <= scan_phase_next;
        current_row <= current_row_next;
        phase_count <= phase_count_next;
        pressed_map <= pressed_map_next;
      end
    end
  end

  kms_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_set     (set),
    .push_ready   (push_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_drive    (row_drive),
    .event_valid  (event_valid),
    .key_down     (key_down),
    .key_code     (key_code),
    .key_row      (key_row),
    .key_column   (key_column),
    .last_of_tick (last_of_tick)
  );

endmodule
`default_nettype wire
